// ===== hw/rtl/sst_pkg.sv =====
`default_nettype none

package sst_pkg;

    typedef enum logic [2:0] {
        MARK_BYTE = 3'd0,
        MARK_END  = 3'd1,
        MARK_SEP  = 3'd2,
        MARK_AT   = 3'd3,
        MARK_DONE = 3'd4
    } t_mark;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [7:0] CH_SEMI = 8'h3B;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_FF   = 8'h0C;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_VT   = 8'h0B;
    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_DQ   = 8'h22;
    localparam logic [7:0] CH_HASH = 8'h23;
    localparam logic [7:0] CH_AT   = 8'h40;

    typedef struct packed {
        logic       kind;
        logic [7:0] text_byte;
    } t_in;

    typedef struct packed {
        t_mark      mark;
        logic [7:0] out_byte;
        logic       last;
    } t_out;

    // results of one transaction, entry r0 first
    typedef struct packed {
        logic [1:0] cnt;
        t_out       r0;
        t_out       r1;
    } t_push;

    typedef struct packed {
        logic [2:0] count;
        logic       full;
    } t_qstat;

endpackage

`default_nettype wire

// ===== hw/rtl/shell_script_tokenizer_unit.sv =====
`default_nettype none

// channel  | valid        | stall        | payload
// ---------+--------------+--------------+-----------------------------
// input    | i_in_valid   | o_in_stall   | i_in_data  (t_in)
// output   | o_out_valid  | i_out_stall  | o_out_data (t_out)
//
// A transaction is decoded in the cycle it is accepted; its 0..2 results
// are in the 4-entry result queue and visible the next cycle.
// The single result port sets the rate: one result per cycle while
// i_out_stall is low. o_in_stall is high while fewer than two
// queue entries are free (registered, no path from i_out_stall).
// Reset (synchronous, active low) clears the flags and empties the queue.

module shell_script_tokenizer_unit (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output wire            o_in_stall,
    input  sst_pkg::t_in   i_in_data,
    output wire            o_out_valid,
    input  wire            i_out_stall,
    output sst_pkg::t_out  o_out_data
);

    logic            w_fire;
    sst_pkg::t_push  w_push;
    sst_pkg::t_qstat w_stat;

    assign w_fire     = i_in_valid && !w_stat.full;
    assign o_in_stall = w_stat.full;

    sst_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_data  (i_in_data),
        .o_push  (w_push)
    );

    sst_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (!i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .o_stat  (w_stat)
    );

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.cnt != 2'd3)
        else $error("more than two results for one transaction");

    a_eos_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && i_in_data.kind == sst_pkg::KIND_EOS |->
            (w_push.cnt == 2'd1 && w_push.r0.mark == sst_pkg::MARK_DONE) ||
            (w_push.cnt == 2'd2 && w_push.r1.mark == sst_pkg::MARK_DONE))
        else $error("end of script without done mark");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && w_fire && w_push.cnt != 2'd0 |=> o_out_valid)
        else $error("pushed result not presented");

    a_stall_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && w_stat.count <= 3'd4)
        else $error("input stalled with empty or overfull queue");

endmodule

`default_nettype wire

// ===== hw/rtl/sst_decode.sv =====
`default_nettype none

module sst_decode (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_fire,
    input  sst_pkg::t_in   i_data,
    output sst_pkg::t_push o_push
);

    logic r_esc, r_str, r_com, r_tok;
    logic n_esc, n_str, n_com, n_tok;

    logic          v_close;
    logic          v_tail;
    sst_pkg::t_mark v_mark;
    logic [7:0]    v_byte;
    logic          v_plain;
    logic [7:0]    c;

    always_comb begin
        c       = i_data.text_byte;
        n_esc   = r_esc;
        n_str   = r_str;
        n_com   = r_com;
        n_tok   = r_tok;
        v_close = 1'b0;
        v_tail  = 1'b0;
        v_mark  = sst_pkg::MARK_BYTE;
        v_byte  = 8'h00;
        v_plain = 1'b0;
        if (i_data.kind == sst_pkg::KIND_EOS) begin
            v_close = r_tok;
            v_tail  = 1'b1;
            v_mark  = sst_pkg::MARK_DONE;
            n_esc   = 1'b0;
            n_str   = 1'b0;
            n_com   = 1'b0;
            n_tok   = 1'b0;
        end else begin
            if (c == sst_pkg::CH_NL)
                n_com = 1'b0;
            v_plain = !r_str && !n_com && !r_esc;
            case (c) inside
                sst_pkg::CH_NL, sst_pkg::CH_SEMI: begin
                    if (v_plain) begin
                        if (r_tok) begin
                            v_close = 1'b1;
                            v_tail  = 1'b1;
                            v_mark  = sst_pkg::MARK_SEP;
                            n_tok   = 1'b0;
                        end
                    end else begin
                        if (!n_com) begin
                            v_tail = 1'b1;
                            v_byte = c;
                            n_tok  = 1'b1;
                        end
                        n_esc = 1'b0;
                    end
                end
                sst_pkg::CH_SP, sst_pkg::CH_TAB, sst_pkg::CH_FF,
                sst_pkg::CH_CR, sst_pkg::CH_VT: begin
                    if (v_plain) begin
                        v_close = r_tok;
                        n_tok   = 1'b0;
                    end else begin
                        if (!n_com) begin
                            v_tail = 1'b1;
                            v_byte = c;
                            n_tok  = 1'b1;
                        end
                        n_esc = 1'b0;
                    end
                end
                sst_pkg::CH_BSL: begin
                    if (!r_esc && !n_com) begin
                        n_esc = 1'b1;
                    end else if (!n_com) begin
                        v_tail = 1'b1;
                        v_byte = c;
                        n_tok  = 1'b1;
                        n_esc  = 1'b0;
                    end
                end
                sst_pkg::CH_DQ: begin
                    if (!r_esc && !n_com) begin
                        n_str = !r_str;
                    end else if (!n_com) begin
                        v_tail = 1'b1;
                        v_byte = c;
                        n_tok  = 1'b1;
                        n_esc  = 1'b0;
                    end
                end
                sst_pkg::CH_HASH: begin
                    if (!r_esc && !r_str) begin
                        n_com = 1'b1;
                    end else if (!n_com) begin
                        v_tail = 1'b1;
                        v_byte = c;
                        n_tok  = 1'b1;
                        n_esc  = 1'b0;
                    end
                end
                sst_pkg::CH_AT: begin
                    if (r_esc) begin
                        v_tail = 1'b1;
                        v_byte = c;
                        n_tok  = 1'b1;
                        n_esc  = 1'b0;
                    end else begin
                        v_close = r_tok;
                        v_tail  = 1'b1;
                        v_mark  = sst_pkg::MARK_AT;
                        n_tok   = 1'b0;
                    end
                end
                default: begin
                    if (!n_com) begin
                        v_tail = 1'b1;
                        v_byte = c;
                        n_tok  = 1'b1;
                        n_esc  = 1'b0;
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_push.cnt         = {v_close & v_tail, v_close ^ v_tail};
        o_push.r0.mark     = v_close ? sst_pkg::MARK_END : v_mark;
        o_push.r0.out_byte = v_close ? 8'h00 : v_byte;
        o_push.r0.last     = !(v_close && v_tail);
        o_push.r1.mark     = v_mark;
        o_push.r1.out_byte = v_byte;
        o_push.r1.last     = 1'b1;
        if (!i_fire)
            o_push.cnt = 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc <= 1'b0;
            r_str <= 1'b0;
            r_com <= 1'b0;
            r_tok <= 1'b0;
        end else if (i_fire) begin
            r_esc <= n_esc;
            r_str <= n_str;
            r_com <= n_com;
            r_tok <= n_tok;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sst_rq.sv =====
`default_nettype none

module sst_rq (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  sst_pkg::t_push  i_push,
    input  wire             i_pop,
    output wire             o_valid,
    output sst_pkg::t_out   o_data,
    output sst_pkg::t_qstat o_stat
);

    sst_pkg::t_out r_mem [4];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_count;
    logic [2:0] n_count;
    logic [1:0] w_wr1;
    logic       w_pop;

    assign w_pop   = i_pop && (r_count != 3'd0);
    assign w_wr1   = r_wr + 2'd1;
    assign n_count = r_count + {1'b0, i_push.cnt} - {2'b00, w_pop};

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0)
            r_mem[r_wr] <= i_push.r0;
        if (i_push.cnt == 2'd2)
            r_mem[w_wr1] <= i_push.r1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 2'd0;
            r_rd    <= 2'd0;
            r_count <= 3'd0;
        end else begin
            r_wr    <= r_wr + i_push.cnt;
            r_rd    <= r_rd + {1'b0, w_pop};
            r_count <= n_count;
        end
    end

    assign o_valid      = (r_count != 3'd0);
    assign o_data       = r_mem[r_rd];
    assign o_stat.count = r_count;
    assign o_stat.full  = (r_count > 3'd2);

endmodule

`default_nettype wire
